[rtl/rpsb_pkg.sv]
// Shared types and constants for the radial power spectrum binner.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package rpsb_pkg;

  // Store and payload sizes
  localparam int unsigned MAX_DIM_DEF     = 256;
  localparam int unsigned SAMPLE_BITS_DEF = 24;
  localparam int unsigned COORD_W         = 8;
  localparam int unsigned SIZE_W          = 9;
  localparam int unsigned SHIFT_W         = 6;
  localparam int unsigned SEL_W           = 8;
  localparam int unsigned POWER_W         = 64;
  localparam int unsigned COUNT_W         = 25;
  localparam int unsigned REQ_W           = 2;

  // Folded coordinates stay below 256, so the radius squared fits 18 bits
  // and its root fits 9 bits.
  localparam int unsigned KSQ_W  = 18;
  localparam int unsigned ROOT_W = 9;
  localparam int unsigned BIT_W  = $clog2(ROOT_W);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SIZE_W;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_NORM_SHIFT = CFG_IDX_W'(3);

  localparam logic [SIZE_W-1:0]  SIZE_RST  = SIZE_W'(256);
  localparam logic [SHIFT_W-1:0] SHIFT_RST = SHIFT_W'(48);

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ACC   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } rpsb_req_e;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the request word
    logic square;     // fold coordinates, square everything
    logic sum;        // add squares, start the root search
    logic root_step;  // one bit of the root search
    logic rd_bin;     // read the store at the computed bin
    logic acc_wr;     // write the updated bin back
    logic rd_sel;     // read the store at the selected bin
    logic out_load;   // load the result registers
    logic clr_init;   // restart the clearing sweep, drop the flag
    logic clr_step;   // zero one store entry
  } rpsb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic root_done;
    logic bin_ok;
    logic clr_done;
  } rpsb_stat_t;

endpackage

[rtl/rpsb_ctrl.sv]
// Controller of the radial power spectrum binner: sequences one request
// at a time through the datapath. Depends on rpsb_pkg.
module rpsb_ctrl
  import rpsb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [REQ_W-1:0] req_type_i,
  input  rpsb_stat_t       stat_i,
  output rpsb_cmd_t        cmd_o,
  output logic             busy_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_LOOKUP,
    ST_UPDATE,
    ST_RDSEL,
    ST_RDOUT
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          unique case (req_type_i)
            REQ_ACC:   state_d = ST_SQUARE;
            REQ_READ:  state_d = ST_RDSEL;
            REQ_CLEAR: begin
              cmd_o.clr_init = 1'b1;
              state_d        = ST_CLEAR;
            end
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (stat_i.root_done) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // out-of-range bins end here, the datapath sets the drop flag
        cmd_o.rd_bin = 1'b1;
        state_d      = stat_i.bin_ok ? ST_UPDATE : ST_IDLE;
      end
      ST_UPDATE: begin
        cmd_o.acc_wr = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_RDSEL: begin
        cmd_o.rd_sel = 1'b1;
        state_d      = ST_RDOUT;
      end
      ST_RDOUT: begin
        cmd_o.out_load = 1'b1;
        state_d        = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state; reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

[rtl/rpsb_dp.sv]
// Datapath of the radial power spectrum binner: configuration registers,
// squaring, root search, bin stores and result registers. Depends on rpsb_pkg.
module rpsb_dp
  import rpsb_pkg::*;
#(
  parameter int unsigned MAX_DIM     = MAX_DIM_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i,
  input  rpsb_cmd_t                     cmd_i,
  output rpsb_stat_t                    stat_o,
  input  logic [COORD_W-1:0]            coord_x_i,
  input  logic [COORD_W-1:0]            coord_y_i,
  input  logic [COORD_W-1:0]            coord_z_i,
  input  logic signed [SAMPLE_BITS-1:0] real_part_i,
  input  logic signed [SAMPLE_BITS-1:0] imag_part_i,
  input  logic [SEL_W-1:0]              bin_select_i,
  output logic                          done_o,
  output logic [POWER_W-1:0]            bin_power_o,
  output logic [COUNT_W-1:0]            bin_count_o,
  output logic                          dropped_any_o
);

  localparam int unsigned AW   = $clog2(MAX_DIM);
  localparam int unsigned SQ_W = 2 * SAMPLE_BITS;
  localparam int unsigned CW   = 2 * COORD_W;

  // Distance from zero frequency, as a magnitude
  function automatic logic [COORD_W-1:0] fold_abs(logic [COORD_W-1:0] c,
                                                  logic [SIZE_W-1:0]  s);
    logic [SIZE_W:0] diff;
    logic [SIZE_W:0] neg;
    diff = {1'b0, s} - {2'b0, c};
    neg  = -diff;
    if (c > s[SIZE_W-1:1]) begin
      fold_abs = diff[SIZE_W] ? neg[COORD_W-1:0] : diff[COORD_W-1:0];
    end else begin
      fold_abs = c;
    end
  endfunction

  // Configuration registers
  logic [SIZE_W-1:0]  size_x_q, size_y_q, size_z_q;
  logic [SHIFT_W-1:0] shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_RST;
      size_y_q <= SIZE_RST;
      size_z_q <= SIZE_RST;
      shift_q  <= SHIFT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SIZE_X:     size_x_q <= cfg_wdata_i;
        REG_SIZE_Y:     size_y_q <= cfg_wdata_i;
        REG_SIZE_Z:     size_z_q <= cfg_wdata_i;
        REG_NORM_SHIFT: shift_q  <= cfg_wdata_i[SHIFT_W-1:0];
        default:        ;
      endcase
    end
  end

  // Request word
  logic [COORD_W-1:0]            cx_q, cy_q, cz_q;
  logic signed [SAMPLE_BITS-1:0] re_q, im_q;
  logic [SEL_W-1:0]              sel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q  <= coord_x_i;
      cy_q  <= coord_y_i;
      cz_q  <= coord_z_i;
      re_q  <= real_part_i;
      im_q  <= imag_part_i;
      sel_q <= bin_select_i;
    end
  end

  // Squares, one multiplier per term
  logic [COORD_W-1:0]     kx, ky, kz;
  logic signed [SQ_W-1:0] re_sq, im_sq;
  logic [CW-1:0]          kx2_q, ky2_q, kz2_q;
  logic [SQ_W-1:0]        re2_q, im2_q;

  assign kx    = fold_abs(cx_q, size_x_q);
  assign ky    = fold_abs(cy_q, size_y_q);
  assign kz    = fold_abs(cz_q, size_z_q);
  assign re_sq = re_q * re_q;
  assign im_sq = im_q * im_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      kx2_q <= kx * kx;
      ky2_q <= ky * ky;
      kz2_q <= kz * kz;
      re2_q <= unsigned'(re_sq);
      im2_q <= unsigned'(im_sq);
    end
  end

  // Radius squared and magnitude squared
  logic [KSQ_W-1:0]   ksq_q;
  logic [POWER_W-1:0] mag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      ksq_q <= KSQ_W'(kx2_q) + KSQ_W'(ky2_q) + KSQ_W'(kz2_q);
      mag_q <= POWER_W'(re2_q) + POWER_W'(im2_q);
    end
  end

  // Root search: try one bit per cycle, highest first
  logic [ROOT_W-1:0] root_q, trial;
  logic [BIT_W-1:0]  bit_q;
  logic [KSQ_W-1:0]  trial_sq;

  assign trial    = root_q | (ROOT_W'(1) << bit_q);
  assign trial_sq = KSQ_W'(trial) * KSQ_W'(trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      root_q <= '0;
      bit_q  <= BIT_W'(ROOT_W - 1);
    end else if (cmd_i.root_step) begin
      if (trial_sq <= ksq_q) begin
        root_q <= trial;
      end
      bit_q <= bit_q - BIT_W'(1);
    end
  end

  // Bin must lie below every size and below the store depth
  logic bin_ok;
  assign bin_ok = (SIZE_W'(root_q) < size_x_q) && (SIZE_W'(root_q) < size_y_q) &&
                  (SIZE_W'(root_q) < size_z_q) && (32'(root_q) < 32'(MAX_DIM));

  // Clearing sweep counter
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_init) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // Sticky drop flag
  logic drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q <= 1'b0;
    end else if (cmd_i.clr_init) begin
      drop_q <= 1'b0;
    end else if (cmd_i.rd_bin && !bin_ok) begin
      drop_q <= 1'b1;
    end
  end

  // Bin stores: one write and one registered read per cycle
  logic [POWER_W-1:0] pw_mem  [MAX_DIM];
  logic [COUNT_W-1:0] cnt_mem [MAX_DIM];
  logic [POWER_W-1:0] rd_pw_q;
  logic [COUNT_W-1:0] rd_cnt_q;
  logic [AW-1:0]      raddr, waddr, wr_addr_q;
  logic [POWER_W-1:0] wr_pw;
  logic [COUNT_W-1:0] wr_cnt;
  logic               mem_re, mem_we;
  logic [POWER_W:0]   psum;

  assign mem_re = cmd_i.rd_bin || cmd_i.rd_sel;
  assign raddr  = cmd_i.rd_bin ? AW'(root_q) : AW'(sel_q);
  assign mem_we = cmd_i.acc_wr || cmd_i.clr_step;
  assign waddr  = cmd_i.clr_step ? clr_cnt_q : wr_addr_q;

  // Saturating update of the addressed bin
  assign psum = {1'b0, rd_pw_q} + {1'b0, mag_q};

  always_comb begin
    wr_pw  = '0;
    wr_cnt = '0;
    if (cmd_i.acc_wr) begin
      wr_pw  = psum[POWER_W] ? '1 : psum[POWER_W-1:0];
      wr_cnt = (rd_cnt_q == '1) ? rd_cnt_q : rd_cnt_q + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_bin) begin
      wr_addr_q <= AW'(root_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_pw_q  <= pw_mem[raddr];
      rd_cnt_q <= cnt_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pw_mem[waddr]  <= wr_pw;
      cnt_mem[waddr] <= wr_cnt;
    end
  end

  // Result registers; a select beyond the store reads as zero
  logic               sel_ok_q;
  logic               done_q;
  logic [POWER_W-1:0] power_q;
  logic [COUNT_W-1:0] count_q;
  logic               dropped_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_sel) begin
      sel_ok_q <= (32'(sel_q) < 32'(MAX_DIM));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      power_q   <= sel_ok_q ? (rd_pw_q >> shift_q) : '0;
      count_q   <= sel_ok_q ? rd_cnt_q : '0;
      dropped_q <= drop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.out_load;
    end
  end

  assign stat_o.root_done = (bit_q == '0);
  assign stat_o.bin_ok    = bin_ok;
  assign stat_o.clr_done  = (clr_cnt_q == AW'(MAX_DIM - 1));

  assign done_o        = done_q;
  assign bin_power_o   = power_q;
  assign bin_count_o   = count_q;
  assign dropped_any_o = dropped_q;

endmodule

[rtl/radial_power_spectrum_binner.sv]
// Radial power spectrum binner, top level: controller plus datapath.
// Depends on rpsb_pkg, rpsb_ctrl and rpsb_dp.
//
// Usage. Raise start_i with a request word while busy_o is low; the word is
// taken at that clock edge. An accumulate request folds the coordinates,
// finds the bin as the integer root of the radius squared and adds the
// sample's squared magnitude and one count to that bin. It keeps busy_o high
// through the square, sum, nine-step root search, lookup and update states
// (the update is skipped when the bin is out of range and the sample is
// dropped); the next sample is taken only once busy_o is low again. A read
// request passes through the store read and output load states, then strobes
// done_o for one cycle with the bin's power, count and drop flag on the
// result ports; the next read is taken only once busy_o falls. A clear
// request sweeps the stores one entry per cycle, with busy_o high. Reset
// loads the register defaults and starts the same sweep. Results cannot be
// held off: take each while done_o is high. Configuration writes are taken
// at any edge with cfg_we_i high.
module radial_power_spectrum_binner
  import rpsb_pkg::*;
#(
  parameter int unsigned MAX_DIM     = MAX_DIM_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [REQ_W-1:0]              req_type_i,
  input  logic [COORD_W-1:0]            coord_x_i,
  input  logic [COORD_W-1:0]            coord_y_i,
  input  logic [COORD_W-1:0]            coord_z_i,
  input  logic signed [SAMPLE_BITS-1:0] real_part_i,
  input  logic signed [SAMPLE_BITS-1:0] imag_part_i,
  input  logic [SEL_W-1:0]              bin_select_i,
  output logic                          done_o,
  output logic [POWER_W-1:0]            bin_power_o,
  output logic [COUNT_W-1:0]            bin_count_o,
  output logic                          dropped_any_o
);

  rpsb_cmd_t  cmd;
  rpsb_stat_t stat;

  rpsb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  rpsb_dp #(
    .MAX_DIM     (MAX_DIM),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .real_part_i   (real_part_i),
    .imag_part_i   (imag_part_i),
    .bin_select_i  (bin_select_i),
    .done_o        (done_o),
    .bin_power_o   (bin_power_o),
    .bin_count_o   (bin_count_o),
    .dropped_any_o (dropped_any_o)
  );

endmodule

[rtl/rpsb_checker.sv]
// Port-level checks for the radial power spectrum binner, with the bind
// that attaches them to the top level. Depends on rpsb_pkg.
module rpsb_checker
  import rpsb_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic [REQ_W-1:0] req_type_i,
  input logic             done_o
);

  // A read word strobes its result after the store read and output load states
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_type_i == REQ_READ) |-> ##3 done_o)
    else $error("read result missing three cycles after the request");

  // Other words never produce the strobe in the slot where a read result would come
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_type_i != REQ_READ) |-> ##3 !done_o)
    else $error("result strobe without a read request");

  // One request at a time, so the strobe is never high on consecutive clocks
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // The strobe comes while the block is already free for the next word
  a_done_idle: assert property (@(posedge clk_i)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

endmodule

bind radial_power_spectrum_binner rpsb_checker u_rpsb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .req_type_i (req_type_i),
  .done_o     (done_o)
);
